>>> rtl/core/auto_hysteresis_slicer_defines.svh
// Assertion macros shared by the slicer RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef AUTO_HYSTERESIS_SLICER_DEFINES_SVH
`define AUTO_HYSTERESIS_SLICER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define AHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define AHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/ahs_pkg.sv
package ahs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int WIDE_W           = 32;

    // Q16 fractions for the auto thresholds: 0.2 and 0.6.
    localparam int Q_FRAC = 16;
    localparam int Q_W    = 16;
    localparam logic [Q_W-1:0] Q_LOW  = 16'd13107;
    localparam logic [Q_W-1:0] Q_HIGH = 16'd39322;

    // Margin used when the tracked range collapses.
    localparam int MARGIN = 50;

    localparam logic [CFG_DATA_W-1:0] LOW_THR_RST  = 16'hFF00;
    localparam logic [CFG_DATA_W-1:0] HIGH_THR_RST = 16'h0100;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_EOB    = 2'd1,
        KIND_REARM  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THR   = 2'd0,
        REG_HIGH_THR  = 2'd1,
        REG_AUTO_MODE = 2'd2
    } t_reg_idx;

    // Per-cycle step control from the item register to the extremes tracker.
    typedef struct packed {
        logic fire;
        logic sample;
        logic eob;
        logic rearm;
        logic auto_mode;
    } t_step;

    // Sign extends a configuration word to the widest supported sample width.
    function automatic logic [WIDE_W-1:0] sext_cfg(input logic [CFG_DATA_W-1:0] d);
        return {{(WIDE_W-CFG_DATA_W){d[CFG_DATA_W-1]}}, d};
    endfunction

endpackage

>>> rtl/core/ahs_in_if.sv
interface ahs_in_if #(
    parameter int W = ahs_pkg::SAMPLE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic signed [W-1:0] sample;

    modport source (output valid, kind, sample, input ready);
    modport sink   (input valid, kind, sample, output ready);
endinterface

>>> rtl/core/ahs_out_if.sv
interface ahs_out_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, level, input ready);
    modport sink   (input valid, level, output ready);
endinterface

>>> rtl/core/ahs_cfg_if.sv
interface ahs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ahs_pkg::CFG_IDX_W-1:0]     index;
    logic [ahs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ahs_track.sv
module ahs_track #(
    parameter int W = ahs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ahs_pkg::t_step      i_step,
    input  logic signed [W-1:0] i_sample,
    output logic signed [W-1:0] o_run_max_n,
    output logic signed [W-1:0] o_run_min_n,
    output logic signed [W-1:0] o_block_max,
    output logic signed [W-1:0] o_block_min
);

    localparam logic signed [W-1:0] SMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] NEG_SMAX = {1'b1, {(W-2){1'b0}}, 1'b1};

    logic signed [W-1:0] r_run_max;
    logic signed [W-1:0] r_run_min;
    logic signed [W-1:0] r_block_max;
    logic signed [W-1:0] r_block_min;
    logic signed [W-1:0] n_run_max;
    logic signed [W-1:0] n_run_min;
    logic signed [W-1:0] n_block_max;
    logic signed [W-1:0] n_block_min;

    // Extremes including the sample now in the item register.
    assign o_run_max_n = (i_sample > r_run_max) ? i_sample : r_run_max;
    assign o_run_min_n = (i_sample < r_run_min) ? i_sample : r_run_min;
    assign o_block_max = r_block_max;
    assign o_block_min = r_block_min;

    always_comb begin
        n_run_max   = r_run_max;
        n_run_min   = r_run_min;
        n_block_max = r_block_max;
        n_block_min = r_block_min;
        if (i_step.fire) begin
            if (i_step.eob) begin
                n_block_max = r_run_max;
                n_block_min = r_run_min;
            end else if (i_step.rearm) begin
                n_run_max = NEG_SMAX;
                n_run_min = SMAX;
            end else if (i_step.sample && i_step.auto_mode) begin
                n_run_max = o_run_max_n;
                n_run_min = o_run_min_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max   <= '0;
            r_run_min   <= SMAX;
            r_block_max <= '0;
            r_block_min <= SMAX;
        end else begin
            r_run_max   <= n_run_max;
            r_run_min   <= n_run_min;
            r_block_max <= n_block_max;
            r_block_min <= n_block_min;
        end
    end

endmodule

>>> rtl/core/ahs_thresh.sv
module ahs_thresh #(
    parameter int W = ahs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic signed [W-1:0] i_run_max,
    input  logic signed [W-1:0] i_run_min,
    input  logic signed [W-1:0] i_block_max,
    input  logic signed [W-1:0] i_block_min,
    output logic signed [W-1:0] o_low,
    output logic signed [W-1:0] o_high
);

    localparam int QF = ahs_pkg::Q_FRAC;
    localparam int QW = ahs_pkg::Q_W;
    localparam int PW = W + QF + 2;
    localparam int PROD_W = W + QW;
    localparam logic signed [W-1:0]  MARGIN_W = W'(ahs_pkg::MARGIN);
    localparam logic signed [PW-1:0] RND_BIAS = PW'((1 << QF) - 1);

    logic signed [W:0]      sum_max;
    logic signed [W:0]      sum_min;
    logic signed [W-1:0]    avg_max;
    logic signed [W-1:0]    avg_min;
    logic signed [W-1:0]    range_w;
    logic                   range_pos;
    logic [PROD_W-1:0]      prod_lo;
    logic [PROD_W-1:0]      prod_hi;
    logic signed [PW-1:0]   max_q;
    logic signed [PW-1:0]   min_q;
    logic signed [PW-1:0]   acc_lo;
    logic signed [PW-1:0]   acc_hi;
    logic signed [PW-1:0]   trn_lo;
    logic signed [PW-1:0]   trn_hi;

    // Average with the latched block extremes (floor of the halved sum).
    assign sum_max = {i_run_max[W-1], i_run_max} + {i_block_max[W-1], i_block_max};
    assign sum_min = {i_run_min[W-1], i_run_min} + {i_block_min[W-1], i_block_min};
    assign avg_max = sum_max[W:1];
    assign avg_min = sum_min[W:1];

    assign range_w   = avg_max - avg_min;
    assign range_pos = (range_w > $signed({W{1'b0}}));

    // The products are only used when the range is positive.
    assign prod_lo = {{QW{1'b0}}, range_w} * {{W{1'b0}}, ahs_pkg::Q_LOW};
    assign prod_hi = {{QW{1'b0}}, range_w} * {{W{1'b0}}, ahs_pkg::Q_HIGH};

    assign min_q = {{(PW-W-QF){avg_min[W-1]}}, avg_min, {QF{1'b0}}};
    assign max_q = {{(PW-W-QF){avg_max[W-1]}}, avg_max, {QF{1'b0}}};

    assign acc_lo = min_q + $signed({{(PW-PROD_W){1'b0}}, prod_lo});
    assign acc_hi = max_q - $signed({{(PW-PROD_W){1'b0}}, prod_hi});

    // Scale back down, rounding toward zero.
    assign trn_lo = acc_lo[PW-1] ? (acc_lo + RND_BIAS) : acc_lo;
    assign trn_hi = acc_hi[PW-1] ? (acc_hi + RND_BIAS) : acc_hi;

    always_comb begin
        if (range_pos) begin
            o_low  = trn_lo[QF+W-1:QF];
            o_high = trn_hi[QF+W-1:QF];
        end else begin
            o_low  = i_run_min + MARGIN_W;
            o_high = i_run_max - MARGIN_W;
        end
    end

endmodule

>>> rtl/core/auto_hysteresis_slicer.sv
// Hysteresis slicer for a stream of signed samples. Each sample item yields one
// result item carrying a one-bit level: the level rises to one when the sample
// is above the high threshold, drops to zero when it is below the low threshold,
// and otherwise keeps its previous value. End-of-block and rearm items yield no
// result. With auto mode cleared, the thresholds are the two configuration
// registers. With auto mode set, every sample first updates a running maximum
// and minimum; each is averaged with the value latched at the last end-of-block
// item, and the thresholds become min + 0.2 * range and max - 0.6 * range, or
// run_min + 50 and run_max - 50 when the range is not positive. The derived
// thresholds are written back into the threshold registers, so they remain in
// force after auto mode is cleared. Throughput is one item per clock while
// results are taken: an item sits in the input register, where the extremes
// update, the threshold derivation (two constant multiplies) and the compare
// are done, and its result is presented from the output register at the next
// edge. The input register and the output register are separate stages, so a
// new item is taken while an earlier result still waits. Configuration writes
// are accepted in every cycle and must only be issued while the slicer is idle.
`include "auto_hysteresis_slicer_defines.svh"

module auto_hysteresis_slicer #(
    parameter int SAMPLE_WIDTH = ahs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ahs_in_if.sink     i_item,
    ahs_out_if.source  o_result,
    ahs_cfg_if.sink    i_cfg
);

    localparam int W = SAMPLE_WIDTH;

    // Threshold reset values, brought to the sample width.
    localparam logic signed [W-1:0] LOW_RST  =
        W'(ahs_pkg::sext_cfg(ahs_pkg::LOW_THR_RST));
    localparam logic signed [W-1:0] HIGH_RST =
        W'(ahs_pkg::sext_cfg(ahs_pkg::HIGH_THR_RST));

    // Input register stage.
    logic                r_in_valid;
    logic [1:0]          r_kind;
    logic signed [W-1:0] r_sample;

    // Configuration and level state.
    logic signed [W-1:0] r_low_thr;
    logic signed [W-1:0] r_high_thr;
    logic                r_auto;
    logic                r_level;
    logic                r_out_valid;

    logic signed [W-1:0] n_low_thr;
    logic signed [W-1:0] n_high_thr;
    logic                n_auto;
    logic                n_level;
    logic                n_out_valid;
    logic                n_in_valid;

    logic                is_sample;
    logic                out_free;
    logic                fire;
    logic                in_take;
    logic                cfg_take;
    ahs_pkg::t_step      step;

    logic signed [W-1:0] run_max_n;
    logic signed [W-1:0] run_min_n;
    logic signed [W-1:0] block_max;
    logic signed [W-1:0] block_min;
    logic signed [W-1:0] auto_low;
    logic signed [W-1:0] auto_high;
    logic signed [W-1:0] use_low;
    logic signed [W-1:0] use_high;
    logic [ahs_pkg::WIDE_W-1:0] cfg_wide;

    // The held item moves on when it yields no result or the output slot frees up.
    assign is_sample = (r_kind == ahs_pkg::KIND_SAMPLE);
    assign out_free  = !r_out_valid || o_result.ready;
    assign fire      = r_in_valid && (!is_sample || out_free);
    assign i_item.ready = !r_in_valid || fire;
    assign in_take   = i_item.valid && i_item.ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_take    = i_cfg.valid;
    assign cfg_wide    = ahs_pkg::sext_cfg(i_cfg.data);

    assign o_result.valid = r_out_valid;
    assign o_result.level = r_level;

    assign step.fire      = fire;
    assign step.sample    = is_sample;
    assign step.eob       = (r_kind == ahs_pkg::KIND_EOB);
    assign step.rearm     = (r_kind == ahs_pkg::KIND_REARM);
    assign step.auto_mode = r_auto;

    ahs_track #(
        .W (W)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sample    (r_sample),
        .o_run_max_n (run_max_n),
        .o_run_min_n (run_min_n),
        .o_block_max (block_max),
        .o_block_min (block_min)
    );

    ahs_thresh #(
        .W (W)
    ) u_thresh (
        .i_run_max   (run_max_n),
        .i_run_min   (run_min_n),
        .i_block_max (block_max),
        .i_block_min (block_min),
        .o_low       (auto_low),
        .o_high      (auto_high)
    );

    // In auto mode the thresholds follow the extremes that include this sample.
    assign use_low  = r_auto ? auto_low  : r_low_thr;
    assign use_high = r_auto ? auto_high : r_high_thr;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_level     = r_level;
        n_low_thr   = r_low_thr;
        n_high_thr  = r_high_thr;
        n_auto      = r_auto;

        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end

        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        if (fire && is_sample) begin
            n_out_valid = 1'b1;
            if (r_sample > use_high) begin
                n_level = 1'b1;
            end else if (r_sample < use_low) begin
                n_level = 1'b0;
            end
            if (r_auto) begin
                n_low_thr  = auto_low;
                n_high_thr = auto_high;
            end
        end

        if (cfg_take) begin
            case (i_cfg.index)
                ahs_pkg::REG_LOW_THR: begin
                    n_low_thr = cfg_wide[W-1:0];
                end
                ahs_pkg::REG_HIGH_THR: begin
                    n_high_thr = cfg_wide[W-1:0];
                end
                ahs_pkg::REG_AUTO_MODE: begin
                    n_auto = i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= 1'b0;
            r_low_thr   <= LOW_RST;
            r_high_thr  <= HIGH_RST;
            r_auto      <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_level     <= n_level;
            r_low_thr   <= n_low_thr;
            r_high_thr  <= n_high_thr;
            r_auto      <= n_auto;
        end
    end

    // Payload of the input stage needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind   <= i_item.kind;
            r_sample <= i_item.sample;
        end
    end

    // A sample that leaves the input stage always lands in the output register.
    `AHS_ASSERT_NEXT(a_sample_gives_result, i_clk, i_rst_n, fire && is_sample, r_out_valid)

    // Items without a result never raise the output valid on their own.
    `AHS_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n, fire && !is_sample, r_out_valid == ($past(r_out_valid) && !$past(o_result.ready)))

    // In auto mode the running maximum covers the sample just processed.
    `AHS_ASSERT_NEXT(a_run_max_covers, i_clk, i_rst_n, fire && is_sample && r_auto, run_max_n >= $past(r_sample))

    // An empty input stage always takes the next item.
    `AHS_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, i_item.ready)

endmodule

>>> dv/ahs_level_checker.sv
// Watches the item, result and register channels of the slicer. Keeps its own
// copy of the thresholds and the tracked extremes, works out the level that
// each accepted sample must produce, and compares it with the result items.
module ahs_level_checker
    import ahs_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  logic                  i_item_ready,
    input  logic [1:0]            i_item_kind,
    input  logic [SW-1:0]         i_item_sample,
    input  logic                  i_result_valid,
    input  logic                  i_result_ready,
    input  logic                  i_result_level,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int SAMPLE_MAX = (1 << (SW - 1)) - 1;

    logic signed [SW-1:0] low_thr;
    logic signed [SW-1:0] high_thr;
    logic                 auto_on;
    logic                 level_now;
    logic signed [SW-1:0] run_hi;
    logic signed [SW-1:0] run_lo;
    logic signed [SW-1:0] blk_hi;
    logic signed [SW-1:0] blk_lo;

    logic expected_levels[$];
    int   fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_cnt++;
    endtask

    task automatic slice_item(input logic [1:0] kind, input logic signed [SW-1:0] smp);
        int                   hi_avg;
        int                   lo_avg;
        logic signed [SW-1:0] span;
        longint               lo_q;
        longint               hi_q;
        case (kind)
            KIND_EOB: begin
                blk_hi = run_hi;
                blk_lo = run_lo;
            end
            KIND_REARM: begin
                run_hi = SW'(-SAMPLE_MAX);
                run_lo = SW'(SAMPLE_MAX);
            end
            KIND_SAMPLE: begin
                if (auto_on) begin
                    if (smp > run_hi)
                        run_hi = smp;
                    if (smp < run_lo)
                        run_lo = smp;
                    // Arithmetic shift gives the floor of the average.
                    hi_avg = (int'(run_hi) + int'(blk_hi)) >>> 1;
                    lo_avg = (int'(run_lo) + int'(blk_lo)) >>> 1;
                    span = SW'(hi_avg - lo_avg);
                    if (span <= 0) begin
                        low_thr  = SW'(int'(run_lo) + MARGIN);
                        high_thr = SW'(int'(run_hi) - MARGIN);
                    end else begin
                        lo_q = (longint'(lo_avg) * 65536 + longint'(span) * longint'(Q_LOW))
                               / 65536;
                        hi_q = (longint'(hi_avg) * 65536 - longint'(span) * longint'(Q_HIGH))
                               / 65536;
                        low_thr  = SW'(lo_q);
                        high_thr = SW'(hi_q);
                    end
                end
                if (smp > high_thr)
                    level_now = 1'b1;
                else if (smp < low_thr)
                    level_now = 1'b0;
                expected_levels.push_back(level_now);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        logic exp_level;
        if (!i_rst_n) begin
            low_thr   = SW'($signed(LOW_THR_RST));
            high_thr  = SW'($signed(HIGH_THR_RST));
            auto_on   = 1'b0;
            level_now = 1'b0;
            run_hi    = '0;
            run_lo    = SW'(SAMPLE_MAX);
            blk_hi    = '0;
            blk_lo    = SW'(SAMPLE_MAX);
            expected_levels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LOW_THR:   low_thr = SW'($signed(i_cfg_data));
                    REG_HIGH_THR:  high_thr = SW'($signed(i_cfg_data));
                    REG_AUTO_MODE: auto_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_item_valid && i_item_ready)
                slice_item(i_item_kind, $signed(i_item_sample));
            if (i_result_valid && i_result_ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("level %0b with no sample waiting",
                                              i_result_level));
                end else begin
                    exp_level = expected_levels.pop_front();
                    if (i_result_level !== exp_level)
                        report_mismatch($sformatf("level %0b, expected %0b",
                                                  i_result_level, exp_level));
                end
            end
        end
        o_pending <= expected_levels.size();
    end

endmodule

>>> dv/tb_top.sv
// Top of the slicer testbench. It makes the stimulus, drives the register
// port and the result back-pressure, and gives the verdict. All prediction and
// comparison sits in the level checker instantiated next to the block.
module tb_top;
    import ahs_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int SMAX_S       = (1 << (SW - 1)) - 1;
    // Kind code 3 is unused by the block: such items must be swallowed.
    localparam logic [1:0] KIND_NONE = 2'd3;
    // Register index 3 has no register behind it: writes must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int RESET_CYCLES = 7;
    // End-of-block and rearm items make no result, so after the last result the
    // block may still hold one of them.
    localparam int DRAIN_CYCLES = 4;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 200;
    // Cycles without any accepted item on any channel before giving up.
    localparam int STALL_LIMIT  = 3000;

    logic i_clk;
    logic i_rst_n;
    int   send_gap_pct;
    int   recv_gap_pct;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    logic moved;

    ahs_in_if #(.W(SW)) item_if();
    ahs_out_if          result_if();
    ahs_cfg_if          cfg_if();

    auto_hysteresis_slicer #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    ahs_level_checker #(
        .SW(SW)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_if.valid),
        .i_item_ready   (item_if.ready),
        .i_item_kind    (item_if.kind),
        .i_item_sample  (item_if.sample),
        .i_result_valid (result_if.valid),
        .i_result_ready (result_if.ready),
        .i_result_level (result_if.level),
        .i_cfg_valid    (cfg_if.valid),
        .i_cfg_ready    (cfg_if.ready),
        .i_cfg_index    (cfg_if.index),
        .i_cfg_data     (cfg_if.data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver drops ready at random, at the rate of the current phase.
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            result_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress. A hung block
    // or a lost result shows up here as a long run of silent cycles.
    assign moved = (item_if.valid && item_if.ready) ||
                   (result_if.valid && result_if.ready) ||
                   (cfg_if.valid && cfg_if.ready);

    always @(posedge i_clk) begin
        if (!i_rst_n || moved) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("auto_hysteresis_slicer test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one item, after a random number of idle cycles, and returns at
    // the edge where it is taken. Valid is left high so that back-to-back
    // items never drop it in between.
    task automatic send_item(input logic [1:0] kind, input logic [SW-1:0] smp);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid  <= 1'b1;
        item_if.kind   <= kind;
        item_if.sample <= smp;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Stops the item stream and waits until every expected level has been
    // delivered, then lets any trailing non-result item leave the pipeline.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only touched with the block empty. Skipping the
    // threshold writes leaves whatever auto mode last derived in force.
    task automatic apply_settings(input logic auto_sel, input logic [SW-1:0] lo,
                                  input logic [SW-1:0] hi, input logic with_thr);
        logic [CFG_DATA_W-1:0] mode_word;
        wait_idle();
        if (with_thr) begin
            write_reg(REG_LOW_THR, CFG_DATA_W'(lo));
            write_reg(REG_HIGH_THR, CFG_DATA_W'(hi));
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        // Upper bits of the mode word are noise; only bit zero selects.
        mode_word    = CFG_DATA_W'($urandom);
        mode_word[0] = auto_sel;
        write_reg(REG_AUTO_MODE, mode_word);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int          seg;
        int          done_cnt;
        int          burst;
        int          amp;
        int          dc;
        int          k;
        int          noise;
        logic [SW-1:0] lo_v;
        logic [SW-1:0] hi_v;
        logic [SW-1:0] smp;
        logic [1:0]  kind_v;

        i_rst_n        <= 1'b0;
        item_if.valid  <= 1'b0;
        item_if.kind   <= KIND_SAMPLE;
        item_if.sample <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_LOW_THR;
        cfg_if.data    <= '0;
        send_gap_pct = 7;
        recv_gap_pct = 63;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: the level only moves once a sample is strictly
        // beyond one of them, values equal to a threshold hold it.
        send_item(KIND_SAMPLE, SW'(0));
        send_item(KIND_SAMPLE, SW'(257));
        send_item(KIND_SAMPLE, SW'(256));
        send_item(KIND_SAMPLE, SW'(-256));
        send_item(KIND_SAMPLE, SW'(-257));
        send_item(KIND_SAMPLE, SW'(SMAX_S));
        send_item(KIND_SAMPLE, SW'(-SMAX_S - 1));
        send_item(KIND_NONE, SW'(16'h5a5a));
        // Latch and rearm in manual mode still change the tracked extremes.
        send_item(KIND_EOB, SW'(0));
        send_item(KIND_REARM, SW'(0));

        // Widest window: no sample can cross either threshold.
        apply_settings(1'b0, SW'(-SMAX_S - 1), SW'(SMAX_S), 1'b1);
        send_item(KIND_SAMPLE, SW'(SMAX_S));
        send_item(KIND_SAMPLE, SW'(-SMAX_S - 1));

        // Inverted window: the high test wins for all but the most negative.
        apply_settings(1'b0, SW'(SMAX_S), SW'(-SMAX_S - 1), 1'b1);
        send_item(KIND_SAMPLE, SW'(-SMAX_S));
        send_item(KIND_SAMPLE, SW'(-SMAX_S - 1));
        send_item(KIND_SAMPLE, SW'(0));

        // Auto mode from the rearmed state: first a collapsed range, then
        // full-scale swings, then a latch after which their difference wraps negative.
        apply_settings(1'b1, '0, '0, 1'b0);
        send_item(KIND_SAMPLE, SW'(100));
        send_item(KIND_SAMPLE, SW'(SMAX_S));
        send_item(KIND_SAMPLE, SW'(-SMAX_S - 1));
        send_item(KIND_EOB, SW'($urandom));
        send_item(KIND_SAMPLE, SW'(0));
        send_item(KIND_SAMPLE, SW'(SMAX_S));
        send_item(KIND_SAMPLE, SW'(-SMAX_S - 1));
        send_item(KIND_REARM, SW'($urandom));
        send_item(KIND_SAMPLE, SW'(5));
        send_item(KIND_SAMPLE, SW'(-5));

        // Back to manual: the thresholds derived last stay in force.
        apply_settings(1'b0, '0, '0, 1'b0);
        send_item(KIND_SAMPLE, SW'(0));

        for (seg = 0; seg < SEGMENTS; seg++) begin
            // Idle pattern: sender rarely idle and receiver often stalled,
            // then the reverse, and finally full rate on both sides.
            if (seg == 3) begin
                send_gap_pct = 63;
                recv_gap_pct = 7;
            end else if (seg == 6) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            // New settings per segment, with the sender held back until the
            // block is empty. Thresholds are mostly ordered, sometimes not.
            lo_v = SW'($urandom);
            hi_v = SW'($urandom);
            if ($urandom_range(0, 2) != 0 && $signed(lo_v) > $signed(hi_v)) begin
                smp  = lo_v;
                lo_v = hi_v;
                hi_v = smp;
            end
            apply_settings(seg[0], lo_v, hi_v, $urandom_range(0, 3) != 0);

            done_cnt = 0;
            while (done_cnt < SEG_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any kind, the unused code included.
                    kind_v = 2'($urandom_range(0, 3));
                    send_item(kind_v, SW'($urandom));
                    if (kind_v != KIND_NONE)
                        done_cnt++;
                end else begin
                    // A block of signal: optional rearm, a burst of samples
                    // shaped like a noisy square wave, usually closed by an
                    // end-of-block item that latches the extremes.
                    if ($urandom_range(0, 2) == 0) begin
                        send_item(KIND_REARM, SW'($urandom));
                        done_cnt++;
                    end
                    burst = $urandom_range(1, 40);
                    amp   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SMAX_S)
                                                        : $urandom_range(0, 2000);
                    dc    = int'($urandom_range(0, 2000)) - 1000;
                    for (k = 0; k < burst; k++) begin
                        noise = int'($urandom_range(0, 400)) - 200;
                        case ($urandom_range(0, 9))
                            0: smp = SW'($urandom);
                            1: begin
                                case ($urandom_range(0, 3))
                                    0: smp = SW'(SMAX_S);
                                    1: smp = SW'(-SMAX_S - 1);
                                    2: smp = SW'(-SMAX_S);
                                    default: smp = '0;
                                endcase
                            end
                            default: smp = SW'(dc + (k[2] ? amp : -amp) + noise);
                        endcase
                        send_item(KIND_SAMPLE, smp);
                        done_cnt++;
                    end
                    if ($urandom_range(0, 4) != 0) begin
                        send_item(KIND_EOB, SW'($urandom));
                        done_cnt++;
                    end
                end
            end
        end

        wait_idle();
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("auto_hysteresis_slicer test passed");
        end else begin
            $display("auto_hysteresis_slicer test failed");
        end
        $finish;
    end

endmodule
